>>> rtl/core/utf8d_pkg.sv
// utf8d_pkg: shared constants and types of the utf-8 stream decoder
// used by utf8d_step, utf8d_out and utf8_stream_decoder_top
package utf8d_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W   = 21;
	localparam int PART_W = 15;

	localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
	localparam logic [CP_W-1:0] CP_MIN_2       = 21'h000080;
	localparam logic [CP_W-1:0] CP_MIN_3       = 21'h000800;
	localparam logic [CP_W-1:0] CP_SURR_LO     = 21'h00D800;
	localparam logic [CP_W-1:0] CP_SURR_HI     = 21'h00E000;
	localparam logic [CP_W-1:0] CP_MIN_4       = 21'h010000;
	localparam logic [CP_W-1:0] CP_LIMIT       = 21'h110000;

	localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
	localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
	localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hF8;
	localparam logic [BYTE_W-1:0] MASK_CONT  = 8'hC0;
	localparam logic [BYTE_W-1:0] CODE_LEAD2 = 8'hC0;
	localparam logic [BYTE_W-1:0] CODE_LEAD3 = 8'hE0;
	localparam logic [BYTE_W-1:0] CODE_LEAD4 = 8'hF0;
	localparam logic [BYTE_W-1:0] CODE_CONT  = 8'h80;

	localparam logic [1:0] LEN_IDLE = 2'd0;
	localparam logic [1:0] LEN_TWO  = 2'd1;
	localparam logic [1:0] LEN_THREE = 2'd2;
	localparam logic [1:0] LEN_FOUR = 2'd3;

	typedef struct packed {
		logic            valid;
		logic [CP_W-1:0] code_point;
		logic            is_error;
	} result_t;

endpackage

>>> rtl/core/utf8d_step.sv
// utf8d_step: sequence state registers and the per-byte decode logic
// depends on utf8d_pkg
module utf8d_step (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step_en,
	input  logic [utf8d_pkg::BYTE_W-1:0] byte_s1,
	output utf8d_pkg::result_t           res
);
	import utf8d_pkg::*;

	logic [1:0]        pending_q, pending_d;
	logic [1:0]        seq_len_q, seq_len_d;
	logic [PART_W-1:0] partial_q, partial_d;
	logic [CP_W-1:0]   value;
	logic              ok;

	assign value = {partial_q, byte_s1[5:0]};

	always_comb begin
		unique case (seq_len_q)
			LEN_TWO:   ok = value >= CP_MIN_2;
			LEN_THREE: ok = value >= CP_MIN_3 && (value < CP_SURR_LO || value >= CP_SURR_HI);
			LEN_FOUR:  ok = value >= CP_MIN_4 && value < CP_LIMIT;
			default:   ok = 1'b0;
		endcase
	end

	always_comb begin
		pending_d = pending_q;
		seq_len_d = seq_len_q;
		partial_d = partial_q;
		res       = '{valid: 1'b0, code_point: CP_REPLACEMENT, is_error: 1'b1};
		if (pending_q == 2'd0) begin
			if (!byte_s1[7]) begin
				res = '{valid: 1'b1, code_point: CP_W'(byte_s1), is_error: 1'b0};
			end else if ((byte_s1 & MASK_LEAD2) == CODE_LEAD2) begin
				pending_d = 2'd1;
				seq_len_d = LEN_TWO;
				partial_d = PART_W'(byte_s1[4:0]);
			end else if ((byte_s1 & MASK_LEAD3) == CODE_LEAD3) begin
				pending_d = 2'd2;
				seq_len_d = LEN_THREE;
				partial_d = PART_W'(byte_s1[3:0]);
			end else if ((byte_s1 & MASK_LEAD4) == CODE_LEAD4) begin
				pending_d = 2'd3;
				seq_len_d = LEN_FOUR;
				partial_d = PART_W'(byte_s1[2:0]);
			end else begin
				res.valid = 1'b1;
			end
		end else if ((byte_s1 & MASK_CONT) != CODE_CONT) begin
			pending_d = 2'd0;
			seq_len_d = LEN_IDLE;
			partial_d = '0;
			res.valid = 1'b1;
		end else if (pending_q != 2'd1) begin
			pending_d = pending_q - 2'd1;
			partial_d = value[PART_W-1:0];
		end else begin
			pending_d = 2'd0;
			seq_len_d = LEN_IDLE;
			partial_d = '0;
			res.valid = 1'b1;
			if (ok) begin
				res.code_point = value;
				res.is_error   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
			seq_len_q <= LEN_IDLE;
			partial_q <= '0;
		end else if (step_en) begin
			pending_q <= pending_d;
			seq_len_q <= seq_len_d;
			partial_q <= partial_d;
		end
	end

endmodule

>>> rtl/core/utf8d_out.sv
// utf8d_out: result register toward the output channel
// depends on utf8d_pkg
module utf8d_out (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  utf8d_pkg::result_t         res,
	output logic                       free,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [utf8d_pkg::CP_W-1:0] code_point,
	output logic                       is_error
);
	import utf8d_pkg::*;

	logic            valid_q;
	logic [CP_W-1:0] cp_q;
	logic            err_q;

	// slot can take a new result when empty or being drained this cycle
	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q  <= res.code_point;
			err_q <= res.is_error;
		end
	end

	assign out_valid  = valid_q;
	assign code_point = cp_q;
	assign is_error   = err_q;

endmodule

>>> rtl/core/utf8_stream_decoder_top.sv
// utf8_stream_decoder_top: byte-stream utf-8 decoder, input register, step logic, result register
// depends on utf8d_pkg, utf8d_step, utf8d_out
//
// Takes one byte per transfer on the input channel and gives one code point per completed
// sequence (or malformed byte) on the output channel, with is_error set for each 0xFFFD
// replacement. Throughput is one byte per clock while the input is not stalled; a byte's
// result passes through the input register and then the result register. Lead bytes and
// middle continuation bytes give no result. A stall on the output holds the pending result
// and back-pressures the input once the input register holds a byte that gives a result.
module utf8_stream_decoder_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [utf8d_pkg::BYTE_W-1:0] byte_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [utf8d_pkg::CP_W-1:0]   code_point,
	output logic                         is_error
);
	import utf8d_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              go;
	logic              free;
	result_t           res;

	assign go       = valid_s1 && (!res.valid || free);
	assign in_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= byte_in;
		end
	end

	utf8d_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (go),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	utf8d_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (go && res.valid),
		.res        (res),
		.free       (free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point),
		.is_error   (is_error)
	);

endmodule

>>> verif/tb_utf8_stream_decoder_top.sv
`timescale 1ns / 1ps
// tb_utf8_stream_decoder_top: self-checking bench for the utf-8 stream decoder
// drives directed and random byte sequences, predicts code points in the bench, idles both sides
// depends on utf8d_pkg and utf8_stream_decoder_top
module tb_utf8_stream_decoder_top;
	import utf8d_pkg::*;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            err;
	} decoded_t;

	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_BYTES  = 150;
	localparam int NUM_BYTES   = 1350;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic [BYTE_W-1:0] byte_in   = '0;
	logic              out_stall = 1'b0;
	logic              in_stall;
	logic              out_valid;
	logic [CP_W-1:0]   code_point;
	logic              is_error;

	logic [BYTE_W-1:0] byte_q[$];
	decoded_t          decoded_q[$];

	logic [1:0]        dec_left = '0;
	logic [1:0]        dec_len  = LEN_IDLE;
	logic [PART_W-1:0] dec_acc  = '0;

	int bytes_sent        = 0;
	int points_checked    = 0;
	int replacements_seen = 0;
	int fail_count        = 0;
	int in_gap            = 0;
	int out_gap           = 0;
	int quiet_cycles      = 0;

	utf8_stream_decoder_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.byte_in    (byte_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point),
		.is_error   (is_error)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// idling only away from the tail, and with quiet stretches in between
	function automatic bit bursty();
		return byte_q.size() > TAIL_BYTES && ((byte_q.size() / 120) % 3) != 0;
	endfunction

	function automatic void push_decoded(input logic [CP_W-1:0] cp, input logic err);
		decoded_t d;
		d.cp  = cp;
		d.err = err;
		decoded_q.push_back(d);
	endfunction

	function automatic void decode_byte(input logic [BYTE_W-1:0] b);
		logic [CP_W-1:0] v;
		logic            ok;
		if (dec_left == 2'd0) begin
			if (!b[7]) begin
				push_decoded({13'd0, b}, 1'b0);
			end else if ((b & MASK_LEAD2) == CODE_LEAD2) begin
				dec_left = 2'd1;
				dec_len  = LEN_TWO;
				dec_acc  = PART_W'(b[4:0]);
			end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
				dec_left = 2'd2;
				dec_len  = LEN_THREE;
				dec_acc  = PART_W'(b[3:0]);
			end else if ((b & MASK_LEAD4) == CODE_LEAD4) begin
				dec_left = 2'd3;
				dec_len  = LEN_FOUR;
				dec_acc  = PART_W'(b[2:0]);
			end else begin
				push_decoded(CP_REPLACEMENT, 1'b1);
			end
		end else if ((b & MASK_CONT) != CODE_CONT) begin
			dec_left = 2'd0;
			dec_len  = LEN_IDLE;
			dec_acc  = '0;
			push_decoded(CP_REPLACEMENT, 1'b1);
		end else begin
			v = {dec_acc, b[5:0]};
			dec_left = dec_left - 2'd1;
			if (dec_left != 2'd0) begin
				dec_acc = v[PART_W-1:0];
			end else begin
				case (dec_len)
					LEN_TWO:   ok = v >= CP_MIN_2;
					LEN_THREE: ok = v >= CP_MIN_3 && (v < CP_SURR_LO || v >= CP_SURR_HI);
					default:   ok = v >= CP_MIN_4 && v < CP_LIMIT;
				endcase
				dec_len = LEN_IDLE;
				dec_acc = '0;
				if (ok)
					push_decoded(v, 1'b0);
				else
					push_decoded(CP_REPLACEMENT, 1'b1);
			end
		end
	endfunction

	function automatic void add_cp(input logic [CP_W-1:0] cp);
		if (cp < CP_MIN_2) begin
			byte_q.push_back(cp[7:0]);
		end else if (cp < CP_MIN_3) begin
			byte_q.push_back({3'b110, cp[10:6]});
			byte_q.push_back({2'b10, cp[5:0]});
		end else if (cp < CP_MIN_4) begin
			byte_q.push_back({4'b1110, cp[15:12]});
			byte_q.push_back({2'b10, cp[11:6]});
			byte_q.push_back({2'b10, cp[5:0]});
		end else begin
			byte_q.push_back({5'b11110, cp[20:18]});
			byte_q.push_back({2'b10, cp[17:12]});
			byte_q.push_back({2'b10, cp[11:6]});
			byte_q.push_back({2'b10, cp[5:0]});
		end
	endfunction

	function automatic logic [BYTE_W-1:0] pick_lead();
		logic [BYTE_W-1:0] edge_leads[8];
		edge_leads = '{8'hC0, 8'hC1, 8'hE0, 8'hED, 8'hF0, 8'hF4, 8'hF5, 8'hF7};
		if ($urandom_range(0, 1))
			return edge_leads[$urandom_range(0, 7)];
		return BYTE_W'($urandom_range(8'hC0, 8'hF7));
	endfunction

	function automatic int cont_count(input logic [BYTE_W-1:0] lead);
		if ((lead & MASK_LEAD4) == CODE_LEAD4)
			return 3;
		if ((lead & MASK_LEAD3) == CODE_LEAD3)
			return 2;
		return 1;
	endfunction

	// input side: one byte per transfer from byte_q
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				decode_byte(byte_in);
				bytes_sent++;
				void'(byte_q.pop_front());
			end
			if (in_valid && in_stall) begin
				in_valid <= 1'b1;
			end else if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (byte_q.size() != 0 && bursty() && $urandom_range(0, 7) == 0) begin
				in_gap = $urandom_range(1, 18) - 1;
				in_valid <= 1'b0;
			end else if (byte_q.size() != 0) begin
				in_valid <= 1'b1;
				byte_in  <= byte_q[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side: compare each transfer with the oldest predicted code point
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (decoded_q.size() == 0) begin
					$error("unexpected result: code_point %h is_error %b", code_point, is_error);
					fail_count++;
				end else begin
					if (code_point !== decoded_q[0].cp) begin
						$error("code_point mismatch: expected %h, actual %h",
							decoded_q[0].cp, code_point);
						fail_count++;
					end
					if (is_error !== decoded_q[0].err) begin
						$error("is_error mismatch: expected %b, actual %b",
							decoded_q[0].err, is_error);
						fail_count++;
					end
					if (decoded_q[0].err)
						replacements_seen++;
					points_checked++;
					void'(decoded_q.pop_front());
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else if (bursty() && $urandom_range(0, 7) == 0) begin
				out_gap = $urandom_range(1, 18) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
				$display("tb_utf8_stream_decoder_top failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int                kind;
		int                need;
		int                total;
		logic [CP_W-1:0]   cp;
		logic [BYTE_W-1:0] lead;

		// ascii ends, bad leads, 2/4-byte ends, overlong, surrogate, out of range, broken
		byte_q = {8'h00, 8'h7F, 8'h80, 8'hFF,
			8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hC0, 8'h80,
			8'hE0, 8'h80, 8'h80, 8'hED, 8'hA0, 8'h80,
			8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80,
			8'hC3, 8'h41};

		while (byte_q.size() < NUM_BYTES) begin
			kind = $urandom_range(0, 99);
			if (kind < 25) begin
				byte_q.push_back(BYTE_W'($urandom_range(0, 8'h7F)));
			end else if (kind < 40) begin
				add_cp(CP_W'($urandom_range(CP_MIN_2, CP_MIN_3 - 1)));
			end else if (kind < 55) begin
				cp = CP_W'($urandom_range(CP_MIN_3, CP_MIN_4 - 1));
				if (cp >= CP_SURR_LO && cp < CP_SURR_HI)
					cp = cp ^ 21'h002000;
				add_cp(cp);
			end else if (kind < 70) begin
				add_cp(CP_W'($urandom_range(CP_MIN_4, CP_LIMIT - 1)));
			end else if (kind < 80) begin
				lead = pick_lead();
				byte_q.push_back(lead);
				repeat (cont_count(lead))
					byte_q.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
			end else if (kind < 90) begin
				lead = pick_lead();
				need = cont_count(lead);
				byte_q.push_back(lead);
				repeat ($urandom_range(0, need - 1))
					byte_q.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
				if ($urandom_range(0, 1))
					byte_q.push_back(BYTE_W'($urandom_range(0, 8'h7F)));
				else
					byte_q.push_back(BYTE_W'($urandom_range(8'hC0, 8'hFF)));
			end else begin
				byte_q.push_back(BYTE_W'($urandom_range(0, 255)));
			end
		end
		total = byte_q.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk); while (bytes_sent != total);
		do @(negedge clk); while (decoded_q.size() != 0);
		repeat (8) @(negedge clk);

		$display("sent %0d bytes incl. overlong, surrogate, range and broken sequences",
			bytes_sent);
		$display("checked %0d code points, %0d of them replacements",
			points_checked, replacements_seen);
		if (fail_count == 0)
			$display("tb_utf8_stream_decoder_top passed");
		else
			$display("tb_utf8_stream_decoder_top failed");
		$finish;
	end

endmodule
